// File: sv/kns_pkg.sv
// ============================================================================
// kns_pkg
// Shared types and constants for the bounded top-k nearest selector.
// ============================================================================
package kns_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int DIST_BITS_DEF = 32;
    localparam int TYPE_W        = 32;
    localparam int HASH_W        = 64;
    localparam int HASH_WORDS    = 4;
    localparam int IN_DIST_W     = 32;
    localparam int LIMIT_W       = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_K_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_EN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

    // Request actions.
    localparam logic ACT_OFFER  = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_CMP,
        S_EMIT
    } t_state;

endpackage

// File: sv/kns_mem.sv
// ============================================================================
// kns_mem
// Entry store: one write port and one read port, read data registered.
// ============================================================================
module kns_mem #(
    parameter int WIDTH = 320,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/bounded_top_k_nearest_select.sv
// ============================================================================
// bounded_top_k_nearest_select
// Keeps the k smallest-distance candidates sorted in one entry memory and
// emits them in ascending order on a finish request.
// ============================================================================
// A dropped offer never raises busy; a full-store offer that loses the
// worst-entry compare goes through S_CHECK back to idle. An insertion steps
// through S_SHIFT_RD and S_SHIFT_CMP down the run, after S_CHECK when full. A
// finish shows one result per cycle from the cycle after the first emit read;
// busy drops in the cycle of the final result. Reset sets the count, sequencer
// and config registers, not the candidate or memory. The receiver cannot stall.
module bounded_top_k_nearest_select
#(
    parameter int CAPACITY  = kns_pkg::CAPACITY_DEF,
    parameter int DIST_BITS = kns_pkg::DIST_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic [kns_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kns_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_action,
    input  logic signed [kns_pkg::TYPE_W-1:0] i_entity_type,
    input  logic [kns_pkg::HASH_W-1:0]      i_hash_word0,
    input  logic [kns_pkg::HASH_W-1:0]      i_hash_word1,
    input  logic [kns_pkg::HASH_W-1:0]      i_hash_word2,
    input  logic [kns_pkg::HASH_W-1:0]      i_hash_word3,
    input  logic [kns_pkg::IN_DIST_W-1:0]   i_distance,
    input  logic                            i_row_invalid,
    output logic                            o_valid,
    output logic signed [kns_pkg::TYPE_W-1:0] o_out_entity_type,
    output logic [kns_pkg::HASH_W-1:0]      o_out_hash_word0,
    output logic [kns_pkg::HASH_W-1:0]      o_out_hash_word1,
    output logic [kns_pkg::HASH_W-1:0]      o_out_hash_word2,
    output logic [kns_pkg::HASH_W-1:0]      o_out_hash_word3,
    output logic [kns_pkg::IN_DIST_W-1:0]   o_out_distance,
    output logic                            o_last
);
    import kns_pkg::*;

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int DW  = DIST_BITS;
    localparam int EW  = TYPE_W + HASH_W * HASH_WORDS + DW;
    localparam int HW  = HASH_W * HASH_WORDS;

    // Configuration registers.
    logic [LIMIT_W-1:0]   r_k_limit;
    logic                 r_thr_en;
    logic [IN_DIST_W-1:0] r_threshold;

    // Sequencer state.
    t_state       r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_ptr, n_ptr;
    logic          r_out_v, n_out_v;
    logic          r_out_last, n_out_last;

    // Candidate held during insertion.
    logic [TYPE_W-1:0] r_cand_type;
    logic [HW-1:0]     r_cand_hash;
    logic [DW-1:0]     r_cand_dist;

    // Memory port.
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;

    logic              accept;
    logic [DW+31:0]    d_ext, thr_ext, o_ext;
    logic [DW-1:0]     d_in, thr_in, rd_dist;
    logic [LIMIT_W-1:0] limit;
    logic              full, drop;
    logic [CW-1:0]     count_m1;
    logic [EW-1:0]     cand_entry;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Distances are taken in their low DIST_BITS bits.
    assign d_ext   = {{DW{1'b0}}, i_distance};
    assign thr_ext = {{DW{1'b0}}, r_threshold};
    assign d_in    = d_ext[DW-1:0];
    assign thr_in  = thr_ext[DW-1:0];

    assign rd_dist = mem_rdata[DW-1:0];

    // A limit of zero acts as one, and a limit above capacity is clipped.
    always_comb begin
        if (r_k_limit == '0) begin
            limit = LIMIT_W'(1);
        end else if (r_k_limit > LIMIT_W'(CAPACITY)) begin
            limit = LIMIT_W'(CAPACITY);
        end else begin
            limit = r_k_limit;
        end
    end

    assign full     = (LIMIT_W'(r_count) >= limit);
    assign drop     = i_row_invalid || (r_thr_en && (d_in > thr_in));
    assign count_m1 = r_count - CW'(1);
    assign cand_entry = {r_cand_type, r_cand_hash, r_cand_dist};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_limit   <= LIMIT_W'(CAPACITY_DEF);
            r_thr_en    <= 1'b0;
            r_threshold <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_K_LIMIT:   r_k_limit   <= i_cfg_wdata[LIMIT_W-1:0];
                REG_THR_EN:    r_thr_en    <= i_cfg_wdata[0];
                REG_THRESHOLD: r_threshold <= i_cfg_wdata[IN_DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Candidate capture on each accepted offer.
    always_ff @(posedge i_clk) begin
        if (accept && (i_action == ACT_OFFER)) begin
            r_cand_type <= i_entity_type;
            r_cand_hash <= {i_hash_word3, i_hash_word2, i_hash_word1, i_hash_word0};
            r_cand_dist <= d_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_ptr      <= '0;
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ptr      <= n_ptr;
            r_out_v    <= n_out_v;
            r_out_last <= n_out_last;
        end
    end

    // Next-state logic. An insertion walks from the top of the sorted run
    // downward: each step reads the entry below, and if it is larger than the
    // candidate it moves up one slot; otherwise the candidate lands here.
    // Reads and writes in one step always address different entries, so no
    // forwarding is needed.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_out_v    = 1'b0;
        n_out_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_FINISH) begin
                        n_ptr = '0;
                        if (r_count != '0) begin
                            n_state = S_EMIT;
                        end
                    end else if (!drop) begin
                        if (full) begin
                            n_state = S_CHECK;
                        end else begin
                            n_ptr   = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                            n_state = S_SHIFT_RD;
                        end
                    end
                end
            end
            S_CHECK: begin
                // When full, the candidate must beat the worst kept entry,
                // which it then overwrites.
                if (r_cand_dist < rd_dist) begin
                    n_ptr   = count_m1[AW-1:0];
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT_RD: begin
                if (r_ptr == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SHIFT_CMP;
                end
            end
            S_SHIFT_CMP: begin
                if (rd_dist > r_cand_dist) begin
                    n_ptr   = r_ptr - AW'(1);
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                n_out_v = 1'b1;
                if (r_ptr == count_m1[AW-1:0]) begin
                    n_out_last = 1'b1;
                    n_count    = '0;
                    n_state    = S_IDLE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory control.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = cand_entry;
        mem_re    = 1'b0;
        mem_raddr = r_ptr;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_action == ACT_OFFER) && !drop && full) begin
                    mem_re    = 1'b1;
                    mem_raddr = count_m1[AW-1:0];
                end
            end
            S_SHIFT_RD: begin
                if (r_ptr == '0) begin
                    mem_we = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr - AW'(1);
                end
            end
            S_SHIFT_CMP: begin
                mem_we = 1'b1;
                if (rd_dist > r_cand_dist) begin
                    mem_wdata = mem_rdata;
                end
            end
            S_EMIT: begin
                mem_re = 1'b1;
            end
            default: ;
        endcase
    end

    kns_mem #(
        .WIDTH (EW),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Results come straight from the registered read data.
    assign o_ext             = {32'd0, rd_dist};
    assign o_valid           = r_out_v;
    assign o_last            = r_out_last;
    assign o_out_entity_type = mem_rdata[EW-1 -: TYPE_W];
    assign o_out_hash_word3  = mem_rdata[DW + 4*HASH_W - 1 -: HASH_W];
    assign o_out_hash_word2  = mem_rdata[DW + 3*HASH_W - 1 -: HASH_W];
    assign o_out_hash_word1  = mem_rdata[DW + 2*HASH_W - 1 -: HASH_W];
    assign o_out_hash_word0  = mem_rdata[DW + HASH_W - 1 -: HASH_W];
    assign o_out_distance    = o_ext[IN_DIST_W-1:0];

    // The count never exceeds the memory depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // The final result of a run is shown only after the store was emptied.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (r_count == '0))
        else $error("store not cleared on final result");

    // Results appear only in the cycle after an emit read.
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EMIT))
        else $error("result without emit read");

    // The memory is never written while emitting or idle.
    a_no_stray_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_SHIFT_RD || r_state == S_SHIFT_CMP))
        else $error("memory written outside insertion");

endmodule

// File: tb/sv/tb.sv
// ============================================================================
// tb
// Self-checking bench for the bounded top-k nearest selector. A small sorted
// store model predicts the ordered run emitted on every finish request, and
// a scoreboard compares each result strobe field by field.
// ============================================================================
module tb;
    import kns_pkg::*;

    // Sorted store model plus the queue of results it predicts.
    class nearest_scoreboard;
        typedef struct packed {
            logic signed [TYPE_W-1:0] etype;
            logic [HASH_W-1:0]        h0, h1, h2, h3;
            logic [IN_DIST_W-1:0]     distance;
            logic                     last;
        } entry_t;

        entry_t           kept[$];
        entry_t           pending[$];
        logic [LIMIT_W-1:0]   k_limit = 7'd64;
        logic                 thr_en = 1'b0;
        logic [IN_DIST_W-1:0] thr = '1;
        int               errors = 0;
        int               emitted = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            if (idx == REG_K_LIMIT)
                k_limit = v[LIMIT_W-1:0];
            else if (idx == REG_THR_EN)
                thr_en = v[0];
            else if (idx == REG_THRESHOLD)
                thr = v;
        endfunction

        function void note_request(logic act, entry_t e, logic inval);
            int lim;
            int pos;
            bit full;
            if (act == ACT_FINISH) begin
                foreach (kept[i]) begin
                    entry_t r;
                    r = kept[i];
                    r.last = (i == kept.size() - 1);
                    pending.push_back(r);
                end
                kept.delete();
                return;
            end
            lim = (k_limit == 0) ? 1 : (k_limit > 64 ? 64 : k_limit);
            full = kept.size() >= lim;
            if (inval) return;
            if (thr_en && e.distance > thr) return;
            // A full store only takes a strictly better distance; the worst
            // entry leaves, so the count stays where it is.
            if (full && !(e.distance < kept[kept.size()-1].distance)) return;
            if (full) void'(kept.pop_back());
            pos = 0;
            while (pos < kept.size() && kept[pos].distance <= e.distance) pos++;
            e.last = 1'b0;
            kept.insert(pos, e);
        endfunction

        function void check_result(entry_t got);
            entry_t x;
            emitted++;
            if (pending.size() == 0) begin
                $error("unexpected result, distance %0h", got.distance);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (got.etype !== x.etype) begin
                $error("entity_type exp %0d got %0d", x.etype, got.etype); errors++;
            end
            if (got.h0 !== x.h0) begin
                $error("hash_word0 exp %h got %h", x.h0, got.h0); errors++;
            end
            if (got.h1 !== x.h1) begin
                $error("hash_word1 exp %h got %h", x.h1, got.h1); errors++;
            end
            if (got.h2 !== x.h2) begin
                $error("hash_word2 exp %h got %h", x.h2, got.h2); errors++;
            end
            if (got.h3 !== x.h3) begin
                $error("hash_word3 exp %h got %h", x.h3, got.h3); errors++;
            end
            if (got.distance !== x.distance) begin
                $error("distance exp %h got %h", x.distance, got.distance); errors++;
            end
            if (got.last !== x.last) begin
                $error("last exp %b got %b", x.last, got.last); errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 2000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_wdata = '0;
    logic                      i_action = ACT_OFFER;
    logic signed [TYPE_W-1:0]  i_entity_type = '0;
    logic [HASH_W-1:0]         i_hash_word0 = '0, i_hash_word1 = '0;
    logic [HASH_W-1:0]         i_hash_word2 = '0, i_hash_word3 = '0;
    logic [IN_DIST_W-1:0]      i_distance = '0;
    logic                      i_row_invalid = 1'b0;
    logic                      o_valid;
    logic signed [TYPE_W-1:0]  o_out_entity_type;
    logic [HASH_W-1:0]         o_out_hash_word0, o_out_hash_word1;
    logic [HASH_W-1:0]         o_out_hash_word2, o_out_hash_word3;
    logic [IN_DIST_W-1:0]      o_out_distance;
    logic                      o_last;

    nearest_scoreboard sb;
    int  requests = 0;
    int  finishes = 0;
    int  idle_cycles = 0;
    bit  timed_out = 0;
    bit  quiet = 0;

    bounded_top_k_nearest_select dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Results cannot be held off, so every strobe is checked at the edge
    // that ends its cycle. The watchdog counts cycles with no handshake.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_result({o_out_entity_type, o_out_hash_word0, o_out_hash_word1,
                                 o_out_hash_word2, o_out_hash_word3, o_out_distance,
                                 o_last});
            if (o_valid || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT && !timed_out) begin
                timed_out = 1;
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    // Drives one request and holds it until the block takes it. The start
    // line stays high straight into the next request when no gap follows.
    task automatic send(logic act, logic signed [TYPE_W-1:0] et, logic [IN_DIST_W-1:0] d,
                        logic inval);
        nearest_scoreboard::entry_t e;
        e.etype = et;
        e.h0 = {$urandom, $urandom};
        e.h1 = {$urandom, $urandom};
        e.h2 = {$urandom, $urandom};
        e.h3 = {$urandom, $urandom};
        e.distance = d;
        e.last = 1'b0;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_action      <= act;
        i_entity_type <= et;
        i_hash_word0  <= e.h0;
        i_hash_word1  <= e.h1;
        i_hash_word2  <= e.h2;
        i_hash_word3  <= e.h3;
        i_distance    <= d;
        i_row_invalid <= inval;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(act, e, inval);
        requests++;
        if (act == ACT_FINISH) finishes++;
    endtask

    // Lowers start and lets every expected result drain before any register is
    // touched.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Distances mostly come from a narrow range so ties and evictions occur.
    function automatic logic [IN_DIST_W-1:0] rand_dist();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    task automatic random_batch(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0)
                send(ACT_FINISH, $urandom, $urandom, $urandom_range(0, 1));
            else
                send(ACT_OFFER, $urandom, rand_dist(), $urandom_range(0, 9) == 0);
        end
        send(ACT_FINISH, $urandom, $urandom, 1'b0);
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: finish on an empty store, field extremes, ties, a finish
        // with row_invalid set, and a full store meeting an equal distance.
        send(ACT_FINISH, 0, 0, 1'b0);
        send(ACT_OFFER, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send(ACT_OFFER, 32'sh8000_0000, 32'h0, 1'b0);
        send(ACT_OFFER, -1, 32'h5, 1'b0);
        send(ACT_OFFER, 7, 32'h5, 1'b0);
        send(ACT_OFFER, 9, 32'h3, 1'b1);
        send(ACT_FINISH, 3, 32'h9, 1'b1);
        drain();
        write_reg(REG_K_LIMIT, 2);
        send(ACT_OFFER, 1, 32'h10, 1'b0);
        send(ACT_OFFER, 2, 32'h20, 1'b0);
        send(ACT_OFFER, 3, 32'h20, 1'b0);
        send(ACT_OFFER, 4, 32'h08, 1'b0);
        send(ACT_FINISH, 0, 0, 1'b0);
        drain();
        write_reg(REG_K_LIMIT, 0);
        write_reg(REG_THR_EN, 1);
        write_reg(REG_THRESHOLD, 32'h100);
        send(ACT_OFFER, 5, 32'h101, 1'b0);
        send(ACT_OFFER, 6, 32'h100, 1'b0);
        send(ACT_OFFER, 8, 32'h0, 1'b0);
        send(ACT_FINISH, 0, 0, 1'b0);
        drain();

        // Random phases over several register settings, with one lowering of
        // the limit while the store holds more than the new value.
        write_reg(REG_THR_EN, 0);
        write_reg(REG_K_LIMIT, 127);
        random_batch(90);
        drain();
        write_reg(REG_K_LIMIT, 5);
        write_reg(REG_THR_EN, 1);
        write_reg(REG_THRESHOLD, 32'h20);
        random_batch(90);
        drain();
        write_reg(REG_THRESHOLD, 32'h0);
        write_reg(REG_K_LIMIT, 1);
        random_batch(40);
        drain();
        write_reg(REG_THR_EN, 0);
        write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
        write_reg(REG_K_LIMIT, 64);
        for (int i = 0; i < 70; i++) send(ACT_OFFER, $urandom, rand_dist(), 1'b0);
        drain();
        write_reg(REG_K_LIMIT, 12);
        random_batch(40);
        drain();
        write_reg(REG_K_LIMIT, 20);
        quiet = 1;
        random_batch(70);
        drain();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d requests, %0d finishes and %0d checked results.",
                 requests, finishes, sb.emitted);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: bounded_top_k_nearest_select.f
sv/kns_pkg.sv
sv/kns_mem.sv
sv/bounded_top_k_nearest_select.sv
tb/sv/tb.sv
